>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> src/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// Types and constants shared by the touch point calibrate and settle block.
// ----------------------------------------------------------------------------
package tpcs_pkg;

	localparam int WORD_W   = 16;
	localparam int CAL_W    = 12;
	localparam int ORIENT_W = 3;
	localparam int ATT_W    = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	// Restoring divider: product of two calibration-width values.
	localparam int PROD_W    = 2 * CAL_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int SETTLE_TOLERANCE = 4;
	localparam logic signed [WORD_W-1:0] VALID_X_LIMIT = 16'sd320;
	localparam logic [ATT_W-1:0] ATTEMPT_SAT = 7'd127;

	localparam logic [CAL_W-1:0]    RST_X_MIN    = 12'd200;
	localparam logic [CAL_W-1:0]    RST_X_MAX    = 12'd3800;
	localparam logic [CAL_W-1:0]    RST_Y_MIN    = 12'd200;
	localparam logic [CAL_W-1:0]    RST_Y_MAX    = 12'd3800;
	localparam logic [CAL_W-1:0]    RST_HOR_RES  = 12'd320;
	localparam logic [CAL_W-1:0]    RST_VER_RES  = 12'd240;
	localparam logic [ORIENT_W-1:0] RST_ORIENT   = 3'd0;
	localparam logic [ATT_W-1:0]    RST_MAX_ATT  = 7'd100;

	// Orientation bits.
	localparam int OR_SWAP = 0;
	localparam int OR_INVX = 1;
	localparam int OR_INVY = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN        = 3'd0,
		REG_X_MAX        = 3'd1,
		REG_Y_MIN        = 3'd2,
		REG_Y_MAX        = 3'd3,
		REG_HOR_RES      = 3'd4,
		REG_VER_RES      = 3'd5,
		REG_ORIENTATION  = 3'd6,
		REG_MAX_ATTEMPTS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CAL_W-1:0]    x_min;
		logic [CAL_W-1:0]    x_max;
		logic [CAL_W-1:0]    y_min;
		logic [CAL_W-1:0]    y_max;
		logic [CAL_W-1:0]    hor_res;
		logic [CAL_W-1:0]    ver_res;
		logic [ORIENT_W-1:0] orientation;
		logic [ATT_W-1:0]    max_attempts;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] x_word;
		logic [WORD_W-1:0] y_word;
		logic              new_event;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] x_coord;
		logic signed [WORD_W-1:0] y_coord;
		logic                     pressed;
		logic                     settled;
		logic                     last_attempt;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE    = 3'd0,
		S_MUL     = 3'd1,
		S_DIV     = 3'd2,
		S_STORE   = 3'd3,
		S_FINISH  = 3'd4
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input transaction
		logic mul;       // load the scaled product into the divider
		logic div_step;  // one restoring division step
		logic store;     // write the finished axis
		logic axis_y;    // 0 selects X, 1 selects Y
		logic finish;    // settle check and output register load
	} cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
	} status_t;

endpackage

>>> src/touch_point_calibrate_settle_core.sv
// ----------------------------------------------------------------------------
// touch_point_calibrate_settle_core
// Raw resistive touch words to calibrated screen coordinates with settling.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// touch sample: the raw X and Y conversion words and a flag marking the first
// sample of a pen event. The output channel (out_valid, out_stall, out_data)
// returns exactly one result transaction per sample: the calibrated point,
// whether it is a valid press, whether it has settled against the previous
// point and whether the attempt limit for this pen event has been reached.
// Both axes run through one shared multiplier and one restoring divider that
// produces one quotient bit per cycle over 24 bits, and the next sample is
// accepted the cycle after the result is registered.
// The output register holds a finished result while the receiver stalls;
// the next sample is already being worked on, and only its final write waits
// until the output register is free.
// Reset loads the calibration registers with their defaults and clears the
// previous point and attempt counter. The user writes configuration only
// through the plain write port while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module touch_point_calibrate_settle_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_wr_en,
	input  logic [tpcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpcs_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Sample channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tpcs_pkg::in_item_t                in_data,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output tpcs_pkg::out_item_t               out_data
);

	tpcs_pkg::cfg_t    cfg;
	tpcs_pkg::cmd_t    cmd;
	tpcs_pkg::status_t status;

	// Calibration, resolution, orientation and attempt limit registers.
	tpcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The sequencer owns the input handshake and steps the datapath.
	tpcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// The datapath owns the history state and the output register.
	tpcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> src/tpcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpcs_cfg_regs
// Calibration and orientation registers behind the plain write port.
// ----------------------------------------------------------------------------
module tpcs_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tpcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpcs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tpcs_pkg::cfg_t                    cfg
);

	tpcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min        <= tpcs_pkg::RST_X_MIN;
			cfg_q.x_max        <= tpcs_pkg::RST_X_MAX;
			cfg_q.y_min        <= tpcs_pkg::RST_Y_MIN;
			cfg_q.y_max        <= tpcs_pkg::RST_Y_MAX;
			cfg_q.hor_res      <= tpcs_pkg::RST_HOR_RES;
			cfg_q.ver_res      <= tpcs_pkg::RST_VER_RES;
			cfg_q.orientation  <= tpcs_pkg::RST_ORIENT;
			cfg_q.max_attempts <= tpcs_pkg::RST_MAX_ATT;
		end else if (cfg_wr_en) begin
			unique case (tpcs_pkg::cfg_reg_t'(cfg_index))
				tpcs_pkg::REG_X_MIN:        cfg_q.x_min   <= cfg_data[tpcs_pkg::CAL_W-1:0];
				tpcs_pkg::REG_X_MAX:        cfg_q.x_max   <= cfg_data[tpcs_pkg::CAL_W-1:0];
				tpcs_pkg::REG_Y_MIN:        cfg_q.y_min   <= cfg_data[tpcs_pkg::CAL_W-1:0];
				tpcs_pkg::REG_Y_MAX:        cfg_q.y_max   <= cfg_data[tpcs_pkg::CAL_W-1:0];
				tpcs_pkg::REG_HOR_RES:      cfg_q.hor_res <= cfg_data[tpcs_pkg::CAL_W-1:0];
				tpcs_pkg::REG_VER_RES:      cfg_q.ver_res <= cfg_data[tpcs_pkg::CAL_W-1:0];
				tpcs_pkg::REG_ORIENTATION:
					cfg_q.orientation <= cfg_data[tpcs_pkg::ORIENT_W-1:0];
				tpcs_pkg::REG_MAX_ATTEMPTS:
					cfg_q.max_attempts <= cfg_data[tpcs_pkg::ATT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/tpcs_datapath.sv
// ----------------------------------------------------------------------------
// tpcs_datapath
// Clamp, multiply, shared restoring divider, inversion, settle tracking and
// the output register.
// ----------------------------------------------------------------------------
module tpcs_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tpcs_pkg::cfg_t       cfg,
	input  tpcs_pkg::cmd_t       cmd,
	output tpcs_pkg::status_t    status,
	input  tpcs_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tpcs_pkg::out_item_t  out_data
);

	localparam int W  = tpcs_pkg::WORD_W;
	localparam int CW = tpcs_pkg::CAL_W;
	localparam int PW = tpcs_pkg::PROD_W;
	localparam logic signed [W:0] TOL_POS = (W+1)'(tpcs_pkg::SETTLE_TOLERANCE);
	localparam logic signed [W:0] TOL_NEG = -TOL_POS;

	// Word shifted right by three, less the minimum, clamped at zero.
	// A word with its top bit set is negative after the shift and clamps.
	function automatic logic [CW-1:0] clamp_sub(input logic [W-1:0] word,
			input logic [CW-1:0] lo);
		logic [CW-1:0] v;
		v = word[W-2:W-1-CW];
		if (!word[W-1] && (v > lo))
			return v - lo;
		return '0;
	endfunction

	logic [CW-1:0] d_x_q, d_y_q;
	logic          new_event_q;
	logic [PW-1:0] dq_q;
	logic [CW-1:0] rem_q;
	logic signed [W-1:0] x_q, y_q;
	logic signed [W-1:0] prev_x_q, prev_y_q;
	logic [tpcs_pkg::ATT_W-1:0] attempt_q;
	logic          out_valid_q;
	tpcs_pkg::out_item_t out_q;

	logic [W-1:0]  raw_x, raw_y;
	logic [CW-1:0] d_sel, res_sel, lo_sel, hi_sel, span;
	logic          span_ok, inv_sel;
	logic [PW-1:0] prod;
	logic [CW:0]   trial;
	logic          ge;
	logic [W-1:0]  quot16, axis_val;

	logic signed [W-1:0] prev_x_eff, prev_y_eff;
	logic signed [W:0]   dx, dy;
	logic          valid_pt, near;
	logic [tpcs_pkg::ATT_W-1:0] att_base, att_next;

	// Capture: swap then clamp both axes.
	assign raw_x = cfg.orientation[tpcs_pkg::OR_SWAP] ? in_data.y_word : in_data.x_word;
	assign raw_y = cfg.orientation[tpcs_pkg::OR_SWAP] ? in_data.x_word : in_data.y_word;

	// Axis selection for the shared multiplier and divider.
	always_comb begin
		if (cmd.axis_y) begin
			d_sel   = d_y_q;
			res_sel = cfg.ver_res;
			lo_sel  = cfg.y_min;
			hi_sel  = cfg.y_max;
			inv_sel = cfg.orientation[tpcs_pkg::OR_INVY];
		end else begin
			d_sel   = d_x_q;
			res_sel = cfg.hor_res;
			lo_sel  = cfg.x_min;
			hi_sel  = cfg.x_max;
			inv_sel = cfg.orientation[tpcs_pkg::OR_INVX];
		end
	end

	assign span_ok = hi_sel > lo_sel;
	assign span    = hi_sel - lo_sel;
	assign prod    = PW'(d_sel) * PW'(res_sel);

	// The remainder stays below the span, so it fits CW bits and the trial
	// fits CW+1 bits.
	assign trial = {rem_q, dq_q[PW-1]};
	assign ge    = trial >= {1'b0, span};

	assign quot16   = span_ok ? dq_q[W-1:0] : '0;
	assign axis_val = inv_sel ? (W'(res_sel) - quot16) : quot16;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_x_q       <= clamp_sub(raw_x, cfg.x_min);
			d_y_q       <= clamp_sub(raw_y, cfg.y_min);
			new_event_q <= in_data.new_event;
		end
		if (cmd.mul) begin
			dq_q  <= prod;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[PW-2:0], ge};
			rem_q <= ge ? CW'(trial - {1'b0, span}) : trial[CW-1:0];
		end
		if (cmd.store) begin
			if (cmd.axis_y)
				y_q <= axis_val;
			else
				x_q <= axis_val;
		end
	end

	// Settle check against the previous valid point.
	assign prev_x_eff = new_event_q ? '0 : prev_x_q;
	assign prev_y_eff = new_event_q ? '0 : prev_y_q;
	assign dx = {prev_x_eff[W-1], prev_x_eff} - {x_q[W-1], x_q};
	assign dy = {prev_y_eff[W-1], prev_y_eff} - {y_q[W-1], y_q};
	assign near = (dx > TOL_NEG) && (dx < TOL_POS) && (dy > TOL_NEG) && (dy < TOL_POS);
	assign valid_pt = (y_q > 16'sd0) && !(x_q > tpcs_pkg::VALID_X_LIMIT);

	assign att_base = new_event_q ? '0 : attempt_q;
	assign att_next = (att_base == tpcs_pkg::ATTEMPT_SAT) ? att_base : att_base + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			attempt_q <= '0;
		end else if (cmd.finish) begin
			attempt_q <= att_next;
			if (valid_pt && !near) begin
				prev_x_q <= x_q;
				prev_y_q <= y_q;
			end else begin
				prev_x_q <= prev_x_eff;
				prev_y_q <= prev_y_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.x_coord      <= x_q;
			out_q.y_coord      <= y_q;
			out_q.pressed      <= valid_pt;
			out_q.settled      <= valid_pt && near;
			out_q.last_attempt <= att_next >= cfg.max_attempts;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> src/tpcs_ctrl.sv
// ----------------------------------------------------------------------------
// tpcs_ctrl
// Sequencer: capture, then multiply, divide and store for X and then Y,
// then the settle check into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output tpcs_pkg::cmd_t     cmd,
	input  tpcs_pkg::status_t  status
);

	localparam int CNT_W = tpcs_pkg::DIV_CNT_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tpcs_pkg::DIV_STEPS - 1);

	tpcs_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpcs_pkg::S_IDLE;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		axis_d  = axis_q;
		cmd     = '0;
		cmd.axis_y = axis_q;
		in_stall = 1'b1;
		unique case (state_q)
			tpcs_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					axis_d   = 1'b0;
					state_d  = tpcs_pkg::S_MUL;
				end
			end
			tpcs_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = tpcs_pkg::S_DIV;
			end
			tpcs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST)
					state_d = tpcs_pkg::S_STORE;
				else
					cnt_d = cnt_q + 1'b1;
			end
			tpcs_pkg::S_STORE: begin
				cmd.store = 1'b1;
				if (axis_q) begin
					state_d = tpcs_pkg::S_FINISH;
				end else begin
					axis_d  = 1'b1;
					state_d = tpcs_pkg::S_MUL;
				end
			end
			tpcs_pkg::S_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = tpcs_pkg::S_IDLE;
				end
			end
			default: state_d = tpcs_pkg::S_IDLE;
		endcase
	end

	`ASSERT_PROP(a_accept_starts_x, clk, arst_n, (in_valid && !in_stall) |=> (state_q == tpcs_pkg::S_MUL && !axis_q), "accepted transaction did not start the X axis")
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CNT_LAST, "division step count out of range")
	`ASSERT_PROP(a_finish_waits, clk, arst_n, (state_q == tpcs_pkg::S_FINISH && !status.out_free) |=> (state_q == tpcs_pkg::S_FINISH), "result dropped while output register was full")
	`ASSERT_PROP(a_div_done_store, clk, arst_n, (state_q == tpcs_pkg::S_DIV && cnt_q == CNT_LAST) |=> (state_q == tpcs_pkg::S_STORE && axis_q == $past(axis_q)), "division did not end in a store of the same axis")

endmodule

>>> bench/touch_point_calibrate_settle_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_point_calibrate_settle_core_test
// Self-checking bench for the touch point calibrate and settle core.
// Samples go in through the valid/stall channel, and each accepted sample is
// also run through a predictor that keeps its own calibration and settling
// state. Every result that comes out is checked against the oldest
// prediction, field by field. The run has a short directed part with the
// edge cases of calibration, then random pen events under a range of
// calibration settings. Random gaps are drawn on both channels.
// ----------------------------------------------------------------------------
module touch_point_calibrate_settle_core_test;

	import tpcs_pkg::*;

	// Tracks the calibration and the settling history as the core should, and
	// holds the predicted result of every sample that is still in flight.
	class touch_point_board;
		cfg_t      cfg;
		int        prev_x;
		int        prev_y;
		int        attempts;
		out_item_t pending_points[$];
		int        mismatches;
		int        results;
		int        pressed_seen;
		int        settled_seen;
		int        last_seen;

		function new();
			cfg = '{x_min: RST_X_MIN, x_max: RST_X_MAX, y_min: RST_Y_MIN,
				y_max: RST_Y_MAX, hor_res: RST_HOR_RES, ver_res: RST_VER_RES,
				orientation: RST_ORIENT, max_attempts: RST_MAX_ATT};
			prev_x = 0;
			prev_y = 0;
			attempts = 0;
			mismatches = 0;
			results = 0;
			pressed_seen = 0;
			settled_seen = 0;
			last_seen = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_X_MIN:        cfg.x_min = val;
				REG_X_MAX:        cfg.x_max = val;
				REG_Y_MIN:        cfg.y_min = val;
				REG_Y_MAX:        cfg.y_max = val;
				REG_HOR_RES:      cfg.hor_res = val;
				REG_VER_RES:      cfg.ver_res = val;
				REG_ORIENTATION:  cfg.orientation = val[ORIENT_W-1:0];
				REG_MAX_ATTEMPTS: cfg.max_attempts = val[ATT_W-1:0];
				default: ;
			endcase
		endfunction

		// Keeps the low 16 bits as a two's complement value.
		function int to_word(int v);
			logic signed [WORD_W-1:0] w;
			w = v[WORD_W-1:0];
			return int'(w);
		endfunction

		function int distance(int a, int b);
			return (a < b) ? b - a : a - b;
		endfunction

		function int span_scale(int v, logic [CAL_W-1:0] lo, logic [CAL_W-1:0] hi,
				logic [CAL_W-1:0] res);
			int d;
			int q;
			if (v > int'(lo)) begin
				d = v - int'(lo);
			end else begin
				d = 0;
			end
			if (hi <= lo) begin
				return 0;
			end
			q = (d * int'(res)) / (int'(hi) - int'(lo));
			return to_word(q);
		endfunction

		function out_item_t calibrate_point(in_item_t s);
			out_item_t                r;
			logic signed [WORD_W-1:0] sx;
			logic signed [WORD_W-1:0] sy;
			int                       x;
			int                       y;
			int                       t;
			bit                       ok;
			bit                       still;
			sx = $signed(s.x_word) >>> 3;
			sy = $signed(s.y_word) >>> 3;
			x = int'(sx);
			y = int'(sy);
			if (s.new_event) begin
				prev_x = 0;
				prev_y = 0;
				attempts = 0;
			end
			if (cfg.orientation[OR_SWAP]) begin
				t = x;
				x = y;
				y = t;
			end
			x = span_scale(x, cfg.x_min, cfg.x_max, cfg.hor_res);
			y = span_scale(y, cfg.y_min, cfg.y_max, cfg.ver_res);
			if (cfg.orientation[OR_INVX]) begin
				x = to_word(int'(cfg.hor_res) - x);
			end
			if (cfg.orientation[OR_INVY]) begin
				y = to_word(int'(cfg.ver_res) - y);
			end
			ok = !(y <= 0 || x > int'(VALID_X_LIMIT));
			if (attempts < int'(ATTEMPT_SAT)) begin
				attempts++;
			end
			still = 0;
			if (ok) begin
				if (distance(prev_x, x) < SETTLE_TOLERANCE &&
						distance(prev_y, y) < SETTLE_TOLERANCE) begin
					still = 1;
				end else begin
					prev_x = x;
					prev_y = y;
				end
			end
			r.x_coord = x[WORD_W-1:0];
			r.y_coord = y[WORD_W-1:0];
			r.pressed = ok;
			r.settled = still;
			r.last_attempt = (attempts >= int'(cfg.max_attempts));
			return r;
		endfunction

		function void note_sample(in_item_t s);
			pending_points.push_back(calibrate_point(s));
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results++;
			pressed_seen += got.pressed;
			settled_seen += got.settled;
			last_seen += got.last_attempt;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Result %0d arrived with nothing predicted: %p", results, got);
				end
				return;
			end
			want = pending_points.pop_front();
			if (got.x_coord !== want.x_coord || got.y_coord !== want.y_coord ||
					got.pressed !== want.pressed || got.settled !== want.settled ||
					got.last_attempt !== want.last_attempt) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Result %0d wrong: expected x %0d y %0d p %0b s %0b l %0b",
						results, want.x_coord, want.y_coord, want.pressed,
						want.settled, want.last_attempt);
					$display("    got x %0d y %0d p %0b s %0b l %0b",
						got.x_coord, got.y_coord, got.pressed, got.settled,
						got.last_attempt);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;

	touch_point_calibrate_settle_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	touch_point_board board = new();

	// When calm is set, neither side inserts gaps, so the core runs flat out.
	bit calm;
	int samples_sent;
	int settings_used;
	// Set ahead of a phase to make its first pen event long enough for the
	// attempt counter to reach saturation.
	bit long_event;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A run that is healthy finishes far inside this; it only catches a hang.
	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: before each result transaction the receiver holds stall for
	// a random number of cycles, then takes the result as soon as it shows.
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = calm ? 0 : $urandom_range(0, 13);
			out_stall = (hold > 0);
			repeat (hold) @(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Results are sampled at the rising edge, with the values from before it.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_result(out_data);
		end
	end

	// Offers one sample transaction after a random gap and waits until it is
	// taken. It is entered and left at a falling edge. The valid line is left
	// high on exit, so that a following sample with no gap goes straight out.
	task automatic send_sample(logic [WORD_W-1:0] xw, logic [WORD_W-1:0] yw, logic ev);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = '{x_word: xw, y_word: yw, new_event: ev};
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_sample(in_data);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		board.write_reg(idx, val);
	endtask

	// The upper data bits of the narrow registers are filled at random, since
	// the core is meant to keep only the low bits.
	task automatic load_calibration(int xlo, int xhi, int ylo, int yhi, int hres,
			int vres, int orient, int att);
		write_reg(REG_X_MIN, CFG_DATA_W'(xlo));
		write_reg(REG_X_MAX, CFG_DATA_W'(xhi));
		write_reg(REG_Y_MIN, CFG_DATA_W'(ylo));
		write_reg(REG_Y_MAX, CFG_DATA_W'(yhi));
		write_reg(REG_HOR_RES, CFG_DATA_W'(hres));
		write_reg(REG_VER_RES, CFG_DATA_W'(vres));
		write_reg(REG_ORIENTATION, {9'($urandom_range(0, 511)), 3'(orient)});
		write_reg(REG_MAX_ATTEMPTS, {5'($urandom_range(0, 31)), 7'(att)});
		settings_used++;
	endtask

	// Waits for every predicted result, then for the latency of one sample,
	// so the core is idle before the next configuration or the end of the run.
	task automatic drain();
		in_valid = 1'b0;
		while (board.pending_points.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// A conversion word for a raw 12-bit reading, with random junk in the
	// three bits that the core shifts away.
	function automatic logic [WORD_W-1:0] raw_word(int v);
		logic [WORD_W-1:0] w;
		if (v < 0) begin
			v = 0;
		end
		if (v > 4095) begin
			v = 4095;
		end
		w = {1'b0, v[11:0], 3'($urandom_range(0, 7))};
		return w;
	endfunction

	// Mostly well-formed pen events: a first sample that opens the event, then
	// samples jittering round one spot, tight enough now and then to settle.
	// The rest is raw noise over the whole word range with random event flags.
	task automatic run_events(int n);
		int done;
		int len;
		int bx;
		int by;
		int spread;
		int k;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 4) == 0) begin
				send_sample(WORD_W'($urandom_range(0, 65535)),
					WORD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
				done++;
			end else begin
				len = long_event ? 135 : $urandom_range(1, 12);
				long_event = 0;
				bx = $urandom_range(0, 4095);
				by = $urandom_range(0, 4095);
				spread = $urandom_range(0, 1) ? 3 : 40;
				for (k = 0; k < len; k++) begin
					send_sample(raw_word(bx + $urandom_range(0, 2 * spread) - spread),
						raw_word(by + $urandom_range(0, 2 * spread) - spread), k == 0);
					done++;
				end
			end
		end
	endtask

	initial begin
		int p;
		int xlo;
		int ylo;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 0;
		samples_sent = 0;
		settings_used = 1;
		long_event = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset calibration: X spans 200..3800 onto 320 pixels, Y onto 240.
		send_sample(16'h0000, 16'h0000, 1'b1);            // both axes at zero
		send_sample(16'hFFFF, 16'hFFFF, 1'b0);            // negative words clamp
		send_sample(16'h8000, 16'h8000, 1'b0);            // most negative word
		send_sample(16'h7FFF, 16'h7FFF, 1'b0);            // top of range, X off screen
		send_sample(16'd3800 << 3, 16'd2000 << 3, 1'b0);  // X right on the limit
		send_sample(16'd3812 << 3, 16'd2000 << 3, 1'b0);  // X one past the limit
		send_sample(16'd2000 << 3, 16'd214 << 3, 1'b0);   // Y scales to zero
		send_sample(16'd2000 << 3, 16'd215 << 3, 1'b0);   // Y scales to one
		// Settling within one pen event: a fresh point, the same point again,
		// a neighbour two pixels off, then one four pixels off.
		send_sample(16'd2000 << 3, 16'd2000 << 3, 1'b1);
		send_sample(16'd2000 << 3, 16'd2000 << 3, 1'b0);
		send_sample(16'd2033 << 3, 16'd2000 << 3, 1'b0);
		send_sample(16'd2045 << 3, 16'd2000 << 3, 1'b0);
		// A new event clears the history, so a point by the origin settles at once.
		send_sample(16'd212 << 3, 16'd215 << 3, 1'b1);
		send_sample(16'h5555, 16'hAAAA, 1'b0);
		drain();

		// A zero X span and a negative Y span, all orientation bits, and a
		// limit of zero so that the last-attempt flag is always up.
		load_calibration(1000, 1000, 3000, 1000, 4095, 4095, 7, 0);
		send_sample(16'd2000 << 3, 16'd2000 << 3, 1'b1);
		send_sample(16'h7FFF, 16'h0000, 1'b0);
		send_sample(16'hFFFF, 16'h7FFF, 1'b0);
		drain();

		// A span of one with the largest resolution makes the quotient wrap,
		// and inverting X then wraps the difference too.
		load_calibration(0, 1, 0, 1, 4095, 4095, 2, 1);
		send_sample(16'h7FFF, 16'h7FFF, 1'b1);
		send_sample(16'd1 << 3, 16'd1 << 3, 1'b0);
		send_sample(16'h0000, 16'h0000, 1'b0);
		send_sample(16'd30 << 3, 16'd17 << 3, 1'b0);
		drain();

		// Random part: one calibration setting per phase, every orientation
		// in turn, the register extremes in the first three phases.
		for (p = 0; p < 8; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			case (p)
				0: begin
					load_calibration(0, 4095, 0, 4095, 4095, 4095, p, 127);
				end
				1: begin
					load_calibration(0, 4095, 0, 4095, 320, 240, p, 127);
					long_event = 1;
				end
				2: begin
					load_calibration(4095, 0, 0, 4095, 1, 1, p, 1);
				end
				default: begin
					xlo = $urandom_range(0, 2047);
					ylo = $urandom_range(0, 2047);
					load_calibration(xlo,
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
							xlo + $urandom_range(1, 4095 - xlo),
						ylo,
						($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
							ylo + $urandom_range(1, 4095 - ylo),
						$urandom_range(0, 1) ? $urandom_range(100, 800) :
							$urandom_range(1, 4095),
						$urandom_range(0, 1) ? $urandom_range(100, 800) :
							$urandom_range(1, 4095),
						p,
						$urandom_range(0, 1) ? $urandom_range(1, 15) :
							$urandom_range(1, 127));
				end
			endcase
			run_events(40);
			drain();
		end

		$display("Sent %0d samples under %0d calibration settings; checked %0d results.",
			samples_sent, settings_used, board.results);
		$display("Results seen pressed %0d, settled %0d, at attempt limit %0d; %0d mismatches.",
			board.pressed_seen, board.settled_seen, board.last_seen, board.mismatches);
		if (board.mismatches == 0 && board.pending_points.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
